// ===== design/hcfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcfc_pkg;

  typedef enum logic [1:0] {
    OP_REQ       = 2'd0,
    OP_RESP_HDR  = 2'd1,
    OP_RESP_DATA = 2'd2
  } hcfc_op_t;

  typedef enum logic [1:0] {
    KIND_PARAM   = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_WIRE    = 2'd2
  } hcfc_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_TRUNC = 2'd2
  } hcfc_status_t;

  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;

  typedef struct packed {
    hcfc_kind_t   kind;
    logic [7:0]   byte_value;
    logic [7:0]   command;
    logic [7:0]   version;
    logic [7:0]   param_count;
    hcfc_status_t status;
    logic         old_style;
    logic         last;
  } hcfc_result_t;

  // results of one processed request, in output order
  typedef struct packed {
    logic [1:0]   count;
    hcfc_result_t r2;
    hcfc_result_t r1;
    hcfc_result_t r0;
  } hcfc_batch_t;

  function automatic hcfc_result_t make_param(input logic [7:0] b);
    hcfc_result_t r;
    r = '0;
    r.kind = KIND_PARAM;
    r.byte_value = b;
    return r;
  endfunction

  function automatic hcfc_result_t make_wire(input logic [7:0] b, input logic last);
    hcfc_result_t r;
    r = '0;
    r.kind = KIND_WIRE;
    r.byte_value = b;
    r.last = last;
    return r;
  endfunction

  function automatic hcfc_result_t make_verdict(input logic [7:0] cmd,
                                                input logic [7:0] ver,
                                                input logic [7:0] cnt,
                                                input hcfc_status_t st,
                                                input logic old);
    hcfc_result_t r;
    r = '0;
    r.kind = KIND_VERDICT;
    r.command = cmd;
    r.version = ver;
    r.param_count = cnt;
    r.status = st;
    r.old_style = old;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/hcfc_proc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcfc_proc #(
  parameter int MAX_PARAMS    = 252,
  parameter int REQUEST_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              fire,
  input  wire hcfc_pkg::hcfc_op_t op,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_write,
  input  wire logic [7:0]        result_code,
  input  wire logic [7:0]        resp_len,
  output hcfc_pkg::hcfc_batch_t  batch
);
  import hcfc_pkg::*;

  localparam int LegacyLimI = (MAX_PARAMS < REQUEST_BYTES - 1) ? MAX_PARAMS : REQUEST_BYTES - 1;
  localparam int HdrLimI    = (MAX_PARAMS < REQUEST_BYTES - 4) ? MAX_PARAMS : REQUEST_BYTES - 4;
  localparam int RespLimI   = (MAX_PARAMS < REQUEST_BYTES - 3) ? MAX_PARAMS : REQUEST_BYTES - 3;
  localparam logic [7:0] LEGACY_LIMIT = LegacyLimI[7:0];
  localparam logic [7:0] HDR_LIMIT    = HdrLimI[7:0];
  localparam logic [7:0] RESP_LIMIT   = RespLimI[7:0];

  logic [7:0] version_base;
  logic [8:0] byte_position, byte_position_next;
  logic [7:0] request_sum, request_sum_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_version, held_version_next;
  logic [7:0] held_param_count, held_param_count_next;
  logic       legacy_mode, legacy_mode_next;
  logic       request_closed, request_closed_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic [7:0] response_sum, response_sum_next;

  hcfc_batch_t  res;
  logic         main_emit;
  logic [7:0]   size_c;
  logic [7:0]   rem_dec;
  logic [7:0]   sum_acc;
  hcfc_result_t eow_res;

  always_comb begin
    byte_position_next    = byte_position;
    request_sum_next      = request_sum;
    held_command_next     = held_command;
    held_version_next     = held_version;
    held_param_count_next = held_param_count;
    legacy_mode_next      = legacy_mode;
    request_closed_next   = request_closed;
    bytes_remaining_next  = bytes_remaining;
    response_sum_next     = response_sum;
    res       = '0;
    main_emit = 1'b0;
    eow_res   = '0;
    size_c    = (resp_len > RESP_LIMIT) ? RESP_LIMIT : resp_len;
    rem_dec   = bytes_remaining - 8'd1;
    sum_acc   = response_sum + data_byte;

    case (op)
      OP_REQ: begin
        if (!request_closed) begin
          if (byte_position == 9'd0) begin
            held_command_next     = 8'd0;
            held_version_next     = 8'd0;
            held_param_count_next = 8'd0;
            request_sum_next      = data_byte;
            if (data_byte >= version_base) begin
              legacy_mode_next  = 1'b0;
              held_version_next = data_byte - version_base;
            end else begin
              legacy_mode_next  = 1'b1;
              held_command_next = data_byte;
            end
            byte_position_next = 9'd1;
          end else if (legacy_mode) begin
            main_emit = 1'b1;
            if (held_param_count >= LEGACY_LIMIT) begin
              // overrun: byte dropped, request closed
              res.r0 = make_verdict(held_command, held_version, held_param_count,
                                    ST_TRUNC, legacy_mode);
              request_closed_next = 1'b1;
            end else begin
              res.r0 = make_param(data_byte);
              held_param_count_next = held_param_count + 8'd1;
              byte_position_next    = byte_position + 9'd1;
            end
          end else if (byte_position == 9'd1) begin
            held_command_next  = data_byte;
            request_sum_next   = request_sum + data_byte;
            byte_position_next = 9'd2;
          end else if (byte_position == 9'd2) begin
            held_param_count_next = data_byte;
            request_sum_next      = request_sum + data_byte;
            byte_position_next    = 9'd3;
            if (data_byte > HDR_LIMIT) begin
              main_emit = 1'b1;
              res.r0 = make_verdict(held_command, held_version, data_byte,
                                    ST_TRUNC, legacy_mode);
              request_closed_next = 1'b1;
            end
          end else if (byte_position < ({1'b0, held_param_count} + 9'd3)) begin
            main_emit = 1'b1;
            res.r0 = make_param(data_byte);
            request_sum_next   = request_sum + data_byte;
            byte_position_next = byte_position + 9'd1;
          end else begin
            main_emit = 1'b1;
            res.r0 = make_verdict(held_command, held_version, held_param_count,
                                  (request_sum == data_byte) ? ST_OK : ST_CSUM,
                                  legacy_mode);
            request_closed_next = 1'b1;
          end

          // write ended before the request closed itself
          eow_res = make_verdict(held_command_next, held_version_next,
                                 held_param_count_next,
                                 legacy_mode_next ? ST_OK : ST_TRUNC, legacy_mode_next);
          if (end_of_write && !request_closed_next) begin
            if (main_emit) begin
              res.r1 = eow_res;
            end else begin
              res.r0 = eow_res;
            end
          end
          res.count = {1'b0, main_emit} +
                      {1'b0, end_of_write && !request_closed_next};
        end
        if (end_of_write) begin
          byte_position_next  = 9'd0;
          request_closed_next = 1'b0;
        end
      end
      OP_RESP_HDR: begin
        res.r0 = make_wire(result_code, 1'b0);
        bytes_remaining_next = size_c;
        if (legacy_mode) begin
          response_sum_next = 8'd0;
          if (size_c == 8'd0) begin
            res.r1    = make_wire(8'd0, 1'b1);
            res.count = 2'd2;
          end else begin
            res.count = 2'd1;
          end
        end else begin
          res.r1 = make_wire(size_c, 1'b0);
          response_sum_next = result_code + size_c;
          if (size_c == 8'd0) begin
            res.r2    = make_wire(result_code + size_c, 1'b1);
            res.count = 2'd3;
          end else begin
            res.count = 2'd2;
          end
        end
      end
      OP_RESP_DATA: begin
        if (bytes_remaining != 8'd0) begin
          res.r0 = make_wire(data_byte, 1'b0);
          response_sum_next    = sum_acc;
          bytes_remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            res.r1    = make_wire(sum_acc, 1'b1);
            res.count = 2'd2;
          end else begin
            res.count = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    batch = res;
    if (!fire) begin
      batch.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_base     <= 8'd220;
      byte_position    <= '0;
      request_sum      <= '0;
      held_command     <= '0;
      held_version     <= '0;
      held_param_count <= '0;
      legacy_mode      <= 1'b0;
      request_closed   <= 1'b0;
      bytes_remaining  <= '0;
      response_sum     <= '0;
    end else begin
      if (cfg_we) begin
        version_base <= cfg_wdata;
      end
      if (fire) begin
        byte_position    <= byte_position_next;
        request_sum      <= request_sum_next;
        held_command     <= held_command_next;
        held_version     <= held_version_next;
        held_param_count <= held_param_count_next;
        legacy_mode      <= legacy_mode_next;
        request_closed   <= request_closed_next;
        bytes_remaining  <= bytes_remaining_next;
        response_sum     <= response_sum_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hcfc_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small result queue: head always in slot 0, shifts on pop, takes up to
// three results per cycle.
module hcfc_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hcfc_pkg::hcfc_batch_t batch,
  output logic                       room,
  output logic                       head_valid,
  input  wire logic                  head_ready,
  output hcfc_pkg::hcfc_result_t     head
);
  import hcfc_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(QueueDepth - MaxResults);

  hcfc_result_t    slots [QueueDepth];
  hcfc_result_t    slots_next [QueueDepth];
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] base;
  logic [CntW-1:0] offs;
  logic            pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count != '0);
  assign head       = slots[0];
  assign room       = (count <= RoomMax);

  always_comb begin
    base = count - CntW'(pop);
    offs = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && i < QueueDepth - 1) begin
        slots_next[i] = slots[i+1];
      end else begin
        slots_next[i] = slots[i];
      end
      offs = CntW'(i) - base;
      if (CntW'(i) >= base && offs < CntW'(batch.count)) begin
        case (offs)
          CntW'(0): slots_next[i] = batch.r0;
          CntW'(1): slots_next[i] = batch.r1;
          default:  slots_next[i] = batch.r2;
        endcase
      end
    end
    count_next = base + CntW'(batch.count);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      slots[i] <= slots_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/host_command_frame_checksum_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Host command request deframer and response framer. Each request on the
// slave side is one byte-level step (request byte, response header or response
// data byte); its 0 to 3 results come out on the master side one per cycle
// while m_axis_tready is high. A request is registered, processed by the
// combinational byte-step logic, and its results land in a four-entry result
// queue, which registers them and presents the head. One request per cycle is
// taken while the queue holds at most one result, so single-result requests run
// at one per cycle, else the output port (one result per cycle) sets the rate.
// User must write version_base via cfg_we/cfg_wdata while idle (not enforced).
module host_command_frame_checksum_core #(
  parameter int MAX_PARAMS    = 252,
  parameter int REQUEST_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // data_byte, result_code, resp_len
  input  wire logic [1:0]  s_axis_tuser,  // op
  input  wire logic        s_axis_tlast,  // end_of_write
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // byte_value, command, version,
                                          // param_count, status, old_style, 5'b0
  output logic [1:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast   // last
);
  import hcfc_pkg::*;

  logic         in_valid_q;
  hcfc_op_t     in_op;
  logic [7:0]   in_byte;
  logic         in_eow;
  logic [7:0]   in_rc;
  logic [7:0]   in_size;
  logic         room;
  logic         fire;
  hcfc_batch_t  batch;
  hcfc_result_t head;

  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= hcfc_op_t'(s_axis_tuser);
      in_byte <= s_axis_tdata[7:0];
      in_rc   <= s_axis_tdata[15:8];
      in_size <= s_axis_tdata[23:16];
      in_eow  <= s_axis_tlast;
    end
  end

  hcfc_proc #(
    .MAX_PARAMS    (MAX_PARAMS),
    .REQUEST_BYTES (REQUEST_BYTES)
  ) u_proc (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fire          (fire),
    .op            (in_op),
    .data_byte     (in_byte),
    .end_of_write  (in_eow),
    .result_code   (in_rc),
    .resp_len      (in_size),
    .batch         (batch)
  );

  hcfc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head_ready (m_axis_tready),
    .head       (head)
  );

  assign m_axis_tdata = {5'b0, head.old_style, head.status, head.param_count,
                         head.version, head.command, head.byte_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

import hcfc_pkg::*;

// Tracks the deframer/framer state and holds the results still due from the block.
class frame_tracker;
  localparam int MaxParams    = 252;
  localparam int RequestBytes = 256;

  hcfc_result_t due_results[$];
  int           errors;
  logic [7:0]   version_base;

  int           byte_pos;
  logic [7:0]   req_sum;
  logic [7:0]   hdr_cmd;
  logic [7:0]   hdr_ver;
  logic [7:0]   hdr_cnt;
  bit           legacy;
  bit           req_closed;
  logic [7:0]   resp_left;
  logic [7:0]   resp_sum;

  function new();
    errors       = 0;
    version_base = 8'd220;
    byte_pos     = 0;
    req_sum      = '0;
    hdr_cmd      = '0;
    hdr_ver      = '0;
    hdr_cnt      = '0;
    legacy       = 1'b0;
    req_closed   = 1'b0;
    resp_left    = '0;
    resp_sum     = '0;
  endfunction

  function void push_byte(hcfc_kind_t k, logic [7:0] b, bit fin);
    hcfc_result_t r;
    r = '0;
    r.kind = k;
    r.byte_value = b;
    r.last = fin;
    due_results.push_back(r);
  endfunction

  function void push_verdict(hcfc_status_t st);
    hcfc_result_t r;
    r = '0;
    r.kind = KIND_VERDICT;
    r.command = hdr_cmd;
    r.version = hdr_ver;
    r.param_count = hdr_cnt;
    r.status = st;
    r.old_style = legacy;
    due_results.push_back(r);
    req_closed = 1'b1;
  endfunction

  function void take_request_byte(logic [7:0] b, logic eow);
    if (!req_closed) begin
      if (byte_pos == 0) begin
        hdr_cmd = '0;
        hdr_ver = '0;
        hdr_cnt = '0;
        req_sum = b;
        if (b >= version_base) begin
          legacy = 1'b0;
          hdr_ver = b - version_base;
        end else begin
          legacy = 1'b1;
          hdr_cmd = b;
        end
        byte_pos = 1;
      end else if (legacy) begin
        // old style: count only, overrun closes the request
        if (int'(hdr_cnt) >= MaxParams || 1 + int'(hdr_cnt) >= RequestBytes) begin
          push_verdict(ST_TRUNC);
        end else begin
          push_byte(KIND_PARAM, b, 1'b0);
          hdr_cnt = hdr_cnt + 8'd1;
          byte_pos = byte_pos + 1;
        end
      end else if (byte_pos == 1) begin
        hdr_cmd = b;
        req_sum = req_sum + b;
        byte_pos = 2;
      end else if (byte_pos == 2) begin
        hdr_cnt = b;
        req_sum = req_sum + b;
        byte_pos = 3;
        if (int'(b) > MaxParams || int'(b) + 4 > RequestBytes) push_verdict(ST_TRUNC);
      end else if (byte_pos < 3 + int'(hdr_cnt)) begin
        push_byte(KIND_PARAM, b, 1'b0);
        req_sum = req_sum + b;
        byte_pos = byte_pos + 1;
      end else begin
        push_verdict((req_sum == b) ? ST_OK : ST_CSUM);
      end
      if (eow && !req_closed) push_verdict(legacy ? ST_OK : ST_TRUNC);
    end
    if (eow) begin
      byte_pos = 0;
      req_closed = 1'b0;
    end
  endfunction

  function void note_request(logic [1:0] op, logic [7:0] b, logic eow, logic [7:0] rc,
                             logic [7:0] sz);
    int n_size;
    case (op)
      OP_REQ: take_request_byte(b, eow);
      OP_RESP_HDR: begin
        n_size = int'(sz);
        if (n_size > MaxParams) n_size = MaxParams;
        if (n_size > RequestBytes - 3) n_size = RequestBytes - 3;
        push_byte(KIND_WIRE, rc, 1'b0);
        if (legacy) begin
          resp_sum = '0;
        end else begin
          push_byte(KIND_WIRE, 8'(n_size), 1'b0);
          resp_sum = rc + 8'(n_size);
        end
        resp_left = 8'(n_size);
        if (n_size == 0) push_byte(KIND_WIRE, resp_sum, 1'b1);
      end
      OP_RESP_DATA: begin
        if (resp_left != 0) begin
          push_byte(KIND_WIRE, b, 1'b0);
          resp_sum = resp_sum + b;
          resp_left = resp_left - 8'd1;
          if (resp_left == 0) push_byte(KIND_WIRE, resp_sum, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(hcfc_result_t got);
    hcfc_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d byte %0d", got.kind, got.byte_value);
      errors++;
      return;
    end
    want = due_results.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("byte_value", want.byte_value, got.byte_value);
    compare_field("command", want.command, got.command);
    compare_field("version", want.version, got.version);
    compare_field("param_count", want.param_count, got.param_count);
    compare_field("status", want.status, got.status);
    compare_field("old_style", want.old_style, got.old_style);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb_top;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         QuietLimit = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  frame_tracker sb = new();
  hcfc_result_t seen;
  logic [7:0]   frame_bytes[$];
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           items_sent = 0;
  int           quiet_cycles = 0;

  host_command_frame_checksum_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = '0;
      seen.kind = hcfc_kind_t'(m_axis_tuser);
      seen.byte_value = m_axis_tdata[7:0];
      seen.command = m_axis_tdata[15:8];
      seen.version = m_axis_tdata[23:16];
      seen.param_count = m_axis_tdata[31:24];
      seen.status = hcfc_status_t'(m_axis_tdata[33:32]);
      seen.old_style = m_axis_tdata[34];
      seen.last = m_axis_tlast;
      sb.check_result(seen);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // ends a hung run: counts cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct = 52;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct = 0;
        rx_stall_pct = 52;
      end
      default: begin
        tx_idle_pct = 17;
        rx_stall_pct = 17;
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic eow,
                           input logic [7:0] rc, input logic [7:0] sz);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sz, rc, b};
    s_axis_tuser <= op;
    s_axis_tlast <= eow;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, b, eow, rc, sz);
    items_sent++;
  endtask

  // sends the first n request bytes of frame_bytes, stop on the last one sent
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(OP_REQ, frame_bytes[i], (i == n - 1), rand_byte(), rand_byte());
    end
  endtask

  task automatic send_reply(input logic [7:0] rc, input logic [7:0] sz, input int n_data);
    send_item(OP_RESP_HDR, rand_byte(), 1'($urandom_range(0, 1)), rc, sz);
    repeat (n_data) begin
      send_item(OP_RESP_DATA, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(), rand_byte());
    end
  endtask

  function automatic void build_versioned(input logic [7:0] first, input logic [7:0] cmd,
                                          input int cnt, input bit bad_sum);
    logic [7:0] total;
    frame_bytes.delete();
    frame_bytes.push_back(first);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(8'(cnt));
    repeat (cnt) frame_bytes.push_back(rand_byte());
    total = '0;
    foreach (frame_bytes[i]) total = total + frame_bytes[i];
    if (bad_sum) total = total ^ 8'(1 << $urandom_range(0, 7));
    frame_bytes.push_back(total);
  endfunction

  function automatic void build_legacy(input logic [7:0] cmd, input int cnt);
    frame_bytes.delete();
    frame_bytes.push_back(cmd);
    repeat (cnt) frame_bytes.push_back(rand_byte());
  endfunction

  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_version_base(input logic [7:0] v);
    drain(8);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.version_base = v;
  endtask

  task automatic run_random(input int n_items);
    int start_count;
    int pick;
    int base;
    int sz;
    logic [7:0] first;
    start_count = items_sent;
    base = int'(sb.version_base);
    while (items_sent - start_count < n_items) begin
      pick = $urandom_range(0, 99);
      first = 8'(base + $urandom_range(0, 255 - base));
      if (pick < 35 || (pick < 55 && base == 0)) begin
        build_versioned(first, rand_byte(), $urandom_range(0, 6), ($urandom_range(0, 99) < 15));
        // occasional trailing bytes after the checksum, ignored until the stop
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_byte());
        send_frame(frame_bytes.size());
      end else if (pick < 55) begin
        build_legacy(8'($urandom_range(0, base - 1)), $urandom_range(0, 6));
        send_frame(frame_bytes.size());
      end else if (pick < 80) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        send_reply(rand_byte(), 8'(sz), (sz <= 6) ? sz : $urandom_range(0, 4));
      end else if (pick < 90) begin
        build_versioned(first, rand_byte(), $urandom_range(0, 6), 1'b0);
        send_frame($urandom_range(1, frame_bytes.size() - 1));
      end else if (pick < 95) begin
        frame_bytes.delete();
        frame_bytes.push_back(first);
        frame_bytes.push_back(rand_byte());
        frame_bytes.push_back(8'($urandom_range(253, 255)));
        repeat ($urandom_range(0, 2)) frame_bytes.push_back(rand_byte());
        send_frame(frame_bytes.size());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(2'($urandom_range(0, 3)), rand_byte(), 1'($urandom_range(0, 1)),
                    rand_byte(), rand_byte());
        end
      end
    end
  endtask

  initial begin
    logic [7:0] next_base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    write_version_base(8'd220);

    build_versioned(8'd220, 8'hff, 1, 1'b0);
    send_frame(5);
    send_item(OP_RESP_HDR, rand_byte(), 1'b0, 8'hff, 8'd0);
    // oversized response clamps, then a new header restarts it
    send_item(OP_RESP_HDR, rand_byte(), 1'b1, 8'h00, 8'd255);
    send_item(OP_RESP_DATA, 8'hff, 1'b0, rand_byte(), rand_byte());
    send_item(OP_RESP_HDR, rand_byte(), 1'b0, 8'h12, 8'd1);
    send_item(OP_RESP_DATA, 8'h34, 1'b1, rand_byte(), rand_byte());
    build_versioned(8'd255, 8'h00, 0, 1'b1);
    send_frame(4);
    // stop lands inside the parameters
    build_versioned(8'd220, 8'h01, 2, 1'b0);
    send_frame(4);
    frame_bytes.delete();
    frame_bytes.push_back(8'd221);
    frame_bytes.push_back(8'd5);
    frame_bytes.push_back(8'd253);
    frame_bytes.push_back(8'd0);
    send_frame(4);
    build_legacy(8'h00, 1);
    send_frame(2);
    send_item(OP_RESP_HDR, rand_byte(), 1'b0, 8'h80, 8'd1);
    send_item(OP_RESP_DATA, 8'h7f, 1'b0, rand_byte(), rand_byte());
    send_item(OP_RESP_DATA, 8'h55, 1'b1, rand_byte(), rand_byte());
    send_item(OpUnused, rand_byte(), 1'b1, rand_byte(), rand_byte());

    for (int p = 0; p < 6; p++) begin
      set_idling(idle_mode_t'(p % 4));
      case (p)
        0:       next_base = 8'd0;
        1:       next_base = 8'd255;
        2:       next_base = 8'd1;
        3:       next_base = 8'd254;
        default: next_base = rand_byte();
      endcase
      write_version_base(next_base);
      run_random(36);
    end

    drain(20);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
